// File: sv/segmented_prime_gap_finder_assert.svh
// Assertion macros for the segmented prime gap finder.
// Depends on nothing; included by the top level.
`ifndef SEGMENTED_PRIME_GAP_FINDER_ASSERT_SVH
`define SEGMENTED_PRIME_GAP_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define SPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/spgf_pkg.sv
// Shared constants and controller/datapath interface types for the prime gap finder.
// Depends on nothing.
package spgf_pkg;
    localparam int unsigned WINDOW     = 65536;
    localparam int unsigned BASE_LIMIT = 65536;
    localparam int unsigned BASE_SLOTS = 8192;
    localparam int WIN_AW  = $clog2(WINDOW);
    localparam int BASE_AW = $clog2(BASE_LIMIT);
    localparam int SLOT_AW = $clog2(BASE_SLOTS);
    localparam int CNT_W   = SLOT_AW + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PAIR = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic bs_init;     // start base sieve: reset index and prime count
        logic bs_clear;    // clear flag at bs index
        logic bs_test;     // examine candidate i
        logic bs_mark;     // mark multiple j
        logic q_load;      // capture query
        logic w_fill;      // set window mark
        logic k_fetch;     // read base prime k
        logic k_check;     // compare p*p and start division
        logic div_step;    // one divider step
        logic m_init;      // compute first multiple
        logic m_clear;     // clear one window multiple
        logic s_read;      // scan read
        logic s_eval;      // scan evaluate
        logic res_load;    // load result register
    } spgf_cmd_t;

    typedef struct packed {
        logic bs_clear_done;
        logic bs_i_done;
        logic bs_cur_comp;
        logic bs_j_done;
        logic q_bad;
        logic q_empty;
        logic w_done;
        logic k_done;
        logic k_stop;
        logic div_done;
        logic m_done;
        logic s_done;
    } spgf_stat_t;
endpackage

// File: sv/spgf_datapath.sv
// Datapath: base prime table, window marks, divider and gap scan.
// Depends on spgf_pkg.
module spgf_datapath (
    input  logic                   aclk,
    input  spgf_pkg::spgf_cmd_t    cmd,
    output spgf_pkg::spgf_stat_t   stat,
    input  logic [30:0]            in_low,
    input  logic [30:0]            in_high,
    output logic [1:0]             r_status,
    output logic [30:0]            r_cl,
    output logic [30:0]            r_cr,
    output logic [30:0]            r_fl,
    output logic [30:0]            r_fr
);
    import spgf_pkg::*;

    logic                comp_mem [BASE_LIMIT];
    logic [15:0]         prime_mem [BASE_SLOTS];
    logic                win_mem [WINDOW];

    logic [BASE_AW:0]    bi_reg;      // candidate / clear index
    logic [BASE_AW+1:0]  bj_reg;      // multiple
    logic                bcomp_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [30:0]         low_reg, high_reg;
    logic [WIN_AW:0]     span_reg, wi_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [15:0]         p_reg;
    logic [31:0]         rem_reg, quo_reg;   // restoring divider of (low+p-1)/p
    logic [5:0]          dstep_reg;
    logic [47:0]         m_reg;
    logic                stop_reg;
    logic                wmark_reg;
    logic [30:0]         prev_reg, sgap_reg, lgap_reg;
    logic [30:0]         cl_reg, cr_reg, fl_reg, fr_reg;
    logic                any_reg;
    logic [1:0]          st_reg;

    logic [31:0] dividend;
    logic [32:0] trial;
    logic [47:0] m_first;
    logic [30:0] n_cur, gap;
    logic              b_adv;     // base sieve moves to the next candidate
    logic [BASE_AW-1:0] brd_addr; // flag read address for the coming test

    assign dividend = {1'b0, low_reg} + {16'd0, p_reg} - 32'd1;
    assign trial    = {rem_reg, quo_reg[31]} - {17'd0, p_reg};
    assign n_cur    = low_reg + 31'(wi_reg);
    assign gap      = n_cur - prev_reg;
    assign b_adv    = cmd.bs_mark && stat.bs_j_done || cmd.bs_test && bcomp_reg;
    // The clear pass hands over to the first candidate, two.
    assign brd_addr = (cmd.bs_clear && stat.bs_clear_done) ? BASE_AW'(2) :
                      bi_reg[BASE_AW-1:0] + (b_adv ? BASE_AW'(1) : BASE_AW'(0));

    always_ff @(posedge aclk) begin
        if (cmd.bs_init) begin
            bi_reg  <= '0;
            cnt_reg <= '0;
        end
        if (cmd.bs_clear) begin
            comp_mem[bi_reg[BASE_AW-1:0]] <= 1'b0;
            bi_reg <= (bi_reg == (BASE_AW+1)'(BASE_LIMIT - 1)) ? (BASE_AW+1)'(2) : bi_reg + 1'b1;
        end
        if (cmd.bs_test) begin
            if (!bcomp_reg) begin
                if (cnt_reg < CNT_W'(BASE_SLOTS)) begin
                    prime_mem[cnt_reg[SLOT_AW-1:0]] <= bi_reg[15:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            bj_reg <= {bi_reg, 1'b0};
        end
        if (cmd.bs_mark) begin
            comp_mem[bj_reg[BASE_AW-1:0]] <= 1'b1;
            bj_reg <= bj_reg + (BASE_AW+2)'(bi_reg);
        end
        if (b_adv) begin
            bi_reg <= bi_reg + 1'b1;
        end
        bcomp_reg <= comp_mem[brd_addr];

        if (cmd.q_load) begin
            low_reg  <= (in_low < 31'd2) ? 31'd2 : in_low;
            high_reg <= in_high;
            wi_reg   <= '0;
            k_reg    <= '0;
            prev_reg <= '0;
            sgap_reg <= '1;
            lgap_reg <= '0;
            any_reg  <= 1'b0;
            cl_reg <= '0; cr_reg <= '0; fl_reg <= '0; fr_reg <= '0;
            st_reg <= (in_high < in_low) ? ST_BAD : ST_NO_PAIR;
        end
        if (cmd.q_load) begin
            span_reg <= (WIN_AW+1)'(in_high - ((in_low < 31'd2) ? 31'd2 : in_low) + 31'd1);
        end
        if (cmd.w_fill) begin
            win_mem[wi_reg[WIN_AW-1:0]] <= 1'b1;
            wi_reg <= stat.w_done ? '0 : wi_reg + 1'b1;
        end
        if (cmd.k_fetch) begin
            p_reg <= prime_mem[k_reg[SLOT_AW-1:0]];
        end
        if (cmd.k_check) begin
            stop_reg  <= (p_reg == 16'd0) || ({16'd0, p_reg} * {16'd0, p_reg} > {1'b0, high_reg});
            rem_reg   <= '0;
            quo_reg   <= dividend;
            dstep_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dstep_reg <= dstep_reg + 1'b1;
        end
        if (cmd.m_init) begin
            m_reg <= (m_first < {31'd0, p_reg, 1'b0}) ? {31'd0, p_reg, 1'b0} : m_first;
        end
        if (cmd.m_clear) begin
            if (!stat.m_done) begin
                win_mem[WIN_AW'(m_reg[30:0] - low_reg)] <= 1'b0;
            end
            m_reg <= m_reg + {32'd0, p_reg};
            if (stat.m_done) k_reg <= k_reg + 1'b1;
        end
        if (cmd.s_read) begin
            wmark_reg <= win_mem[wi_reg[WIN_AW-1:0]];
        end
        if (cmd.s_eval) begin
            if (wmark_reg) begin
                if (prev_reg != 31'd0) begin
                    if (gap < sgap_reg) begin
                        sgap_reg <= gap; cl_reg <= prev_reg; cr_reg <= n_cur;
                    end
                    if (gap > lgap_reg) begin
                        lgap_reg <= gap; fl_reg <= prev_reg; fr_reg <= n_cur;
                    end
                    any_reg <= 1'b1;
                end
                prev_reg <= n_cur;
            end
            wi_reg <= wi_reg + 1'b1;
        end
        if (cmd.res_load) begin
            if (stat.q_bad || stat.q_empty) begin
                r_status <= stat.q_bad ? ST_BAD : ST_NO_PAIR;
                r_cl <= '0; r_cr <= '0; r_fl <= '0; r_fr <= '0;
            end else if (any_reg) begin
                r_status <= ST_OK;
                r_cl <= cl_reg; r_cr <= cr_reg; r_fl <= fl_reg; r_fr <= fr_reg;
            end else begin
                r_status <= ST_NO_PAIR;
                r_cl <= '0; r_cr <= '0; r_fl <= '0; r_fr <= '0;
            end
        end
    end

    assign m_first = 48'(quo_reg) * 48'(p_reg);

    always_comb begin
        stat               = '0;
        stat.bs_clear_done = (bi_reg == (BASE_AW+1)'(BASE_LIMIT - 1));
        stat.bs_i_done     = (bi_reg >= (BASE_AW+1)'(BASE_LIMIT));
        stat.bs_cur_comp   = bcomp_reg;
        stat.bs_j_done     = (bj_reg + (BASE_AW+2)'(bi_reg) >= (BASE_AW+2)'(BASE_LIMIT));
        stat.q_bad         = (st_reg == ST_BAD) ||
                             ({1'b0, high_reg} - {1'b0, low_reg} + 32'd1 > 32'(WINDOW) &&
                              high_reg >= low_reg);
        stat.q_empty       = (st_reg != ST_BAD) && (high_reg < low_reg);
        stat.w_done        = (wi_reg + 1'b1 >= span_reg);
        stat.k_done        = (k_reg >= cnt_reg);
        stat.k_stop        = stop_reg;
        stat.div_done      = (dstep_reg == 6'd31);
        stat.m_done        = (m_reg > {17'd0, high_reg});
        stat.s_done        = (wi_reg >= span_reg);
    end
endmodule

// File: sv/spgf_ctrl.sv
// Controller state machine for the prime gap finder.
// Depends on spgf_pkg.
module spgf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spgf_pkg::spgf_cmd_t   cmd,
    input  spgf_pkg::spgf_stat_t  stat
);
    import spgf_pkg::*;

    typedef enum logic [13:0] {
        S_BINIT  = 14'b00000000000001,
        S_BCLR   = 14'b00000000000010,
        S_BTEST  = 14'b00000000000100,
        S_BMARK  = 14'b00000000001000,
        S_IDLE   = 14'b00000000010000,
        S_CHECK  = 14'b00000000100000,
        S_FILL   = 14'b00000001000000,
        S_KFETCH = 14'b00000010000000,
        S_KCHK   = 14'b00000100000000,
        S_DIV    = 14'b00001000000000,
        S_MINIT  = 14'b00010000000000,
        S_MCLR   = 14'b00100000000000,
        S_SCAN   = 14'b01000000000000,
        S_RES    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;   // result register holds an untaken transaction
    logic   eval_reg, eval_next;   // scan pipeline holds a read

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BINIT;
            busy_reg  <= 1'b0;
            eval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            eval_reg  <= eval_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = busy_reg;

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg && !out_ready;
        eval_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_BINIT: begin
                cmd.bs_init = 1'b1;
                state_next  = S_BCLR;
            end
            S_BCLR: begin
                cmd.bs_clear = 1'b1;
                if (stat.bs_clear_done) state_next = S_BTEST;
            end
            S_BTEST: begin
                if (stat.bs_i_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.bs_test = 1'b1;
                    if (!stat.bs_cur_comp) state_next = S_BMARK;
                end
            end
            S_BMARK: begin
                cmd.bs_mark = 1'b1;
                if (stat.bs_j_done) state_next = S_BTEST;
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.q_load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.q_bad || stat.q_empty) state_next = S_RES;
                else state_next = S_FILL;
            end
            S_FILL: begin
                cmd.w_fill = 1'b1;
                if (stat.w_done) state_next = S_KFETCH;
            end
            S_KFETCH: begin
                if (stat.k_done) begin
                    state_next = S_SCAN;
                end else begin
                    cmd.k_fetch = 1'b1;
                    state_next  = S_KCHK;
                end
            end
            S_KCHK: begin
                cmd.k_check = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV: begin
                if (stat.k_stop) begin
                    state_next = S_SCAN;
                end else begin
                    cmd.div_step = 1'b1;
                    if (stat.div_done) state_next = S_MINIT;
                end
            end
            S_MINIT: begin
                cmd.m_init = 1'b1;
                state_next = S_MCLR;
            end
            S_MCLR: begin
                cmd.m_clear = 1'b1;
                if (stat.m_done) state_next = S_KFETCH;
            end
            S_SCAN: begin
                if (eval_reg) cmd.s_eval = 1'b1;
                else if (stat.s_done) state_next = S_RES;
                else begin
                    cmd.s_read = 1'b1;
                    eval_next  = 1'b1;
                end
            end
            S_RES: begin
                if (!busy_reg || out_ready) begin
                    cmd.res_load = 1'b1;
                    busy_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_BINIT;
        endcase
    end
endmodule

// File: sv/segmented_prime_gap_finder.sv
// Segmented sieve prime gap finder: each query transaction carries an inclusive window
// [range_low, range_high] of up to 65536 numbers and returns one result transaction with the
// first closest and first most distant adjacent prime pairs in it. After reset a startup sieve
// fills the base prime table (it clears the flag memory, then tests each candidate and marks
// its multiples) and accepts no query until done. A query then presets the window, runs per
// base prime p with p*p <= range_high one 32-step restoring division for the first multiple
// and clears each multiple in the window, and then scans the window, reading and then
// evaluating each entry. The fill, the clearing and the scan all run through the single-port
// window mark memory, which sets the rate. One query is in flight at a time; the result
// register holds its transaction while the next query is accepted.
// Depends on spgf_pkg, spgf_ctrl, spgf_datapath and the assertion header.
`include "segmented_prime_gap_finder_assert.svh"
module segmented_prime_gap_finder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [30:0] s_range_low,
    input  logic [30:0] s_range_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [30:0] m_closest_left,
    output logic [30:0] m_closest_right,
    output logic [30:0] m_farthest_left,
    output logic [30:0] m_farthest_right
);
    import spgf_pkg::*;

    spgf_cmd_t  cmd;
    spgf_stat_t stat;

    // Controller: sequence base sieve, then per query fill, mark, scan, deliver.
    spgf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: memories, divider, scan registers and the result register.
    spgf_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .stat     (stat),
        .in_low   (s_range_low),
        .in_high  (s_range_high),
        .r_status (m_status),
        .r_cl     (m_closest_left),
        .r_cr     (m_closest_right),
        .r_fl     (m_farthest_left),
        .r_fr     (m_farthest_right)
    );

    // A result never carries pair values unless the status is success.
    `SPG_ASSERT_IMPL(a_zero_fields, aclk, aresetn, m_valid && m_status != ST_OK,
        m_closest_left == 31'd0 && m_farthest_right == 31'd0, "nonzero pair on failure")
    // An accepted query starts its work at once.
    `SPG_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready,
        "ready stayed high after accept")
    // A valid success pair is ordered.
    `SPG_ASSERT_IMPL(a_order, aclk, aresetn, m_valid && m_status == ST_OK,
        m_closest_left < m_closest_right && m_farthest_left < m_farthest_right,
        "pair out of order")
endmodule
